// ----- rtl/scsu_pkg.sv -----
// Shared types and constants for the shadow call stack unwind block.
// Holds the command and status structs passed between controller and datapath.
// No dependencies; compile this file first.
`default_nettype none

package scsu_pkg;

    // Event codes carried by the func field.
    localparam logic FUNC_CALL = 1'b0;
    localparam logic FUNC_RET  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the input transaction
        logic exec_call;     // push a frame, or flag overflow when full
        logic start_search;  // begin a top-down scan of the return addresses
        logic search;        // scan step: issue one read, compare the previous one
        logic top_load;      // take the new top function start from memory
        logic out_load;      // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_call;       // captured event is a call
        logic empty;         // stack holds no frame
        logic hit;           // compared entry matches the return address
        logic hit_bottom;    // the matching entry is the bottom frame
        logic miss;          // bottom frame compared without a match
    } t_status;

endpackage : scsu_pkg

`default_nettype wire

// ----- rtl/shadow_call_stack_unwind_core.sv -----
// Shadow call stack with return-address unwind: controller and datapath.
// Top level of the block. Depends on scsu_pkg, scsu_ctrl and scsu_dpath.
//
// Usage: one input channel (i_in_valid / o_in_stall) carries call and return
// events, one output channel (o_out_valid / i_out_stall) carries exactly one
// result transaction per event, in order. A transaction moves at a rising edge
// where valid is high and stall is low.
// Sequence: a call, or a return on an empty stack, goes from decode straight to
// the finish state. A return scans the stored return addresses from the top,
// one frame per cycle through the registered read port of the return-address
// memory; after a match above the bottom frame, the new top function start is
// read from memory and loaded before the finish state. The scan ends at a match
// or after the bottom frame is compared without one.
// The block works on one event at a time; the next event is accepted as soon
// as the previous result has moved into the output register.
// Reset (synchronous, active low) empties the stack and clears both valid
// flags; the frame memories are not cleared because only frames below the
// frame count are ever read. When the receiver stalls, the result holds in the
// output register and the block finishes the next event, then waits.
`default_nettype none

module shadow_call_stack_unwind_core #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_func,
    input  wire logic [63:0] i_call_address,
    input  wire logic [63:0] i_ret_address,
    input  wire logic [63:0] i_entry_address,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_matched,
    output logic             o_overflow,
    output logic [6:0]       o_frames_removed,
    output logic [6:0]       o_stack_depth,
    output logic [63:0]      o_top_entry_address
);
    import scsu_pkg::*;

    // Command and status between the sequencer and the frame datapath.
    t_cmd    w_cmd;
    t_status w_status;

    scsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    scsu_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_func              (i_func),
        .i_call_address      (i_call_address),
        .i_ret_address       (i_ret_address),
        .i_entry_address     (i_entry_address),
        .o_matched           (o_matched),
        .o_overflow          (o_overflow),
        .o_frames_removed    (o_frames_removed),
        .o_stack_depth       (o_stack_depth),
        .o_top_entry_address (o_top_entry_address)
    );

endmodule : shadow_call_stack_unwind_core

`default_nettype wire

// ----- rtl/scsu_dpath.sv -----
// Datapath of the shadow call stack: frame memories, frame count, scan pipeline
// and output register. Depends on scsu_pkg for the command and status structs.
`default_nettype none

module scsu_dpath #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire scsu_pkg::t_cmd   i_cmd,
    output scsu_pkg::t_status     o_status,
    input  wire logic             i_func,
    input  wire logic [63:0]      i_call_address,
    input  wire logic [63:0]      i_ret_address,
    input  wire logic [63:0]      i_entry_address,
    output logic                  o_matched,
    output logic                  o_overflow,
    output logic [6:0]            o_frames_removed,
    output logic [6:0]            o_stack_depth,
    output logic [63:0]           o_top_entry_address
);
    import scsu_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = CW + 7;

    // Frame memories. The call address store is kept for completeness of the frame.
    logic [63:0] call_mem  [STACK_DEPTH];
    logic [63:0] ret_mem   [STACK_DEPTH];
    logic [63:0] start_mem [STACK_DEPTH];

    logic          r_func;
    logic [63:0]   r_call;
    logic [63:0]   r_ret;
    logic [63:0]   r_entry;

    logic [CW-1:0] r_count;
    logic [63:0]   r_top;

    logic [AW-1:0] r_ptr;
    logic          r_ptr_vld;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic [63:0]   r_rd_ret;
    logic [63:0]   r_start_q;

    logic          r_matched;
    logic          r_overflow;
    logic [CW-1:0] r_removed;

    logic          w_full;
    logic          w_eq;
    logic [AW-1:0] w_top_idx;
    logic [EW-1:0] w_depth_ext;
    logic [EW-1:0] w_removed_ext;

    assign w_full        = (r_count == CW'(STACK_DEPTH));
    assign w_eq          = (r_rd_ret == r_ret);
    assign w_top_idx     = AW'(r_count - CW'(1));
    assign w_depth_ext   = EW'(r_count);
    assign w_removed_ext = EW'(r_removed);

    always_comb begin
        o_status.is_call    = (r_func == FUNC_CALL);
        o_status.empty      = (r_count == '0);
        o_status.hit        = r_rd_vld && w_eq;
        o_status.hit_bottom = (r_rd_idx == '0);
        o_status.miss       = r_rd_vld && !w_eq && (r_rd_idx == '0);
    end

    // Memory write port and registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_call && !w_full) begin
            call_mem[r_count[AW-1:0]]  <= r_call;
            ret_mem[r_count[AW-1:0]]   <= r_ret;
            start_mem[r_count[AW-1:0]] <= r_entry;
        end
        r_rd_ret  <= ret_mem[r_ptr];
        r_start_q <= start_mem[w_top_idx];
    end

    // Stack state and scan control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_top     <= '0;
            r_ptr     <= '0;
            r_ptr_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.exec_call && !w_full) begin
                r_count <= r_count + CW'(1);
                r_top   <= r_entry;
            end
            if (i_cmd.start_search) begin
                r_ptr     <= w_top_idx;
                r_ptr_vld <= 1'b1;
                r_rd_vld  <= 1'b0;
            end else if (i_cmd.search) begin
                r_rd_vld <= r_ptr_vld;
                if (r_ptr == '0) begin
                    r_ptr_vld <= 1'b0;
                end else begin
                    r_ptr <= r_ptr - AW'(1);
                end
                if (o_status.hit) begin
                    r_count <= CW'(r_rd_idx);
                    if (r_rd_idx == '0) begin
                        r_top <= '0;
                    end
                end
            end
            if (i_cmd.top_load) begin
                r_top <= r_start_q;
            end
        end
    end

    // Input capture, per-event result flags and the scan index pipeline.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_call     <= i_call_address;
            r_ret      <= i_ret_address;
            r_entry    <= i_entry_address;
            r_matched  <= 1'b0;
            r_overflow <= 1'b0;
            r_removed  <= '0;
        end
        if (i_cmd.exec_call) begin
            r_matched  <= !w_full;
            r_overflow <= w_full;
        end
        if (i_cmd.search) begin
            r_rd_idx <= r_ptr;
            if (o_status.hit) begin
                r_matched <= 1'b1;
                r_removed <= r_count - CW'(r_rd_idx);
            end
        end
    end

    // Output register; holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_matched           <= r_matched;
            o_overflow          <= r_overflow;
            o_frames_removed    <= w_removed_ext[6:0];
            o_stack_depth       <= w_depth_ext[6:0];
            o_top_entry_address <= r_top;
        end
    end

endmodule : scsu_dpath

`default_nettype wire

// ----- rtl/scsu_ctrl.sv -----
// Controller state machine of the shadow call stack: input and output handshakes
// and the command sequence for the datapath. Depends on scsu_pkg.
`default_nettype none

module scsu_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire scsu_pkg::t_status  i_status,
    output scsu_pkg::t_cmd          o_cmd
);
    import scsu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH,
        ST_TOPRD,
        ST_TOPLD,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_out_free;

    assign w_out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        o_cmd              = '0;
        n_state            = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_status.is_call) begin
                    o_cmd.exec_call = 1'b1;
                    n_state         = ST_FINISH;
                end else if (i_status.empty) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.start_search = 1'b1;
                    n_state            = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_status.hit) begin
                    n_state = i_status.hit_bottom ? ST_FINISH : ST_TOPRD;
                end else if (i_status.miss) begin
                    n_state = ST_FINISH;
                end
            end
            ST_TOPRD: begin
                n_state = ST_TOPLD;
            end
            ST_TOPLD: begin
                o_cmd.top_load = 1'b1;
                n_state        = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_in_stall  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            o_in_stall <= (n_state != ST_IDLE);
            if (o_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule : scsu_ctrl

`default_nettype wire
